// ----- design/sha1_message_digest_assert.svh -----
// ----------------------------------------------------------------------------
// SHA-1 message digest: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication.
`define SHA1MD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHA1MD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1md_pkg
// Types and constants shared by the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	localparam int ROUNDS       = 80;
	localparam int BLOCK_WORDS  = 16;
	localparam int DIGEST_WORDS = 5;
	localparam int QUEUE_DEPTH  = 2;
	localparam int LEN_BYTE     = 56;   // first byte of the length field

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	// One queued input item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} item_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ROUND = 6'b000010,
		ST_FOLD  = 6'b000100,
		ST_PAD   = 6'b001000,
		ST_LEN   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

endpackage

// ----- design/sha1md_if.sv -----
// ----------------------------------------------------------------------------
// sha1md channel interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        last_word;

	modport source (output valid, digest_word, word_number, last_word, input ready);
	modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ----- design/sha1_message_digest.sv -----
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream, five digest words per message.
//
//   channel  dir  payload
//   msg      in   data_byte[7:0], byte_present, end_of_message
//   digest   out  digest_word[31:0], word_number[2:0], last_word
//
// The packer writes each byte into the block buffer; each full block runs the
// 80 rounds on the single round unit, then a fold. The end of a message writes
// padding bytes up to the length field, then the length, then compresses and
// folds each padded block (one or two), then makes five output transfers.
// A two-entry queue takes up to two more msg transfers while the back end is busy;
// after that msg.ready stays low until the back end is idle again.
// arst_n clears control state and loads the initial chain; no clearing pass.
// ----------------------------------------------------------------------------
module sha1_message_digest (
	input  logic          clk,
	input  logic          arst_n,
	sha1md_in_if.sink     msg,
	sha1md_out_if.source  digest
);
	import sha1md_pkg::*;

	item_t q_item;
	logic  q_valid;
	logic  q_ready;

	sha1md_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_ready (q_ready)
	);

	sha1md_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.digest  (digest)
	);

endmodule

// ----- design/sha1md_front.sv -----
// ----------------------------------------------------------------------------
// sha1md_front
// Accepts input items, drops those that carry neither a byte nor an end
// mark, and queues the rest for the compression side.
// ----------------------------------------------------------------------------
module sha1md_front (
	input  logic               clk,
	input  logic               arst_n,
	sha1md_in_if.sink          msg,
	output sha1md_pkg::item_t  q_item,
	output logic               q_valid,
	input  logic               q_ready
);
	import sha1md_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;
	logic               useful;

	assign useful    = msg.byte_present | msg.end_of_message;
	assign msg.ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign push      = msg.valid & msg.ready & useful;
	assign q_valid   = count_q != '0;
	assign pop       = q_valid & q_ready;
	assign q_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data_byte: msg.data_byte,
				byte_present: msg.byte_present, end_of_message: msg.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/sha1md_back.sv -----
// ----------------------------------------------------------------------------
// sha1md_back
// Packs bytes into the block buffer, pads, runs the 80 rounds one per cycle
// and hands the five digest words to the output register.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_assert.svh"

module sha1md_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1md_pkg::item_t  q_item,
	input  logic               q_valid,
	output logic               q_ready,
	sha1md_out_if.source       digest
);
	import sha1md_pkg::*;

	state_t       state_q;
	logic [31:0]  w_q [BLOCK_WORDS];
	logic [31:0]  h_q [DIGEST_WORDS];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic [60:0]  total_q;
	logic [5:0]   pad_pos_q;
	logic         first_q;
	logic         extra_q;
	logic         pend_pad_q;
	logic         final_q;
	logic [2:0]   emit_idx_q;
	logic         out_valid_q;
	logic [31:0]  out_word_q;
	logic [2:0]   out_num_q;
	logic         out_last_q;

	logic         pop;
	logic [5:0]   pos;
	logic [5:0]   pad_start;
	logic         byte_we;
	logic [5:0]   byte_pos;
	logic [7:0]   byte_val;
	logic [31:0]  byte_word;
	logic [4:0]   byte_sh;
	logic         start_comp;
	logic         emit_load;
	logic [31:0]  f;
	logic [31:0]  k;
	logic [31:0]  t;
	logic [31:0]  w_new;

	assign q_ready   = state_q == ST_IDLE;
	assign pop       = q_valid & q_ready;
	assign pos       = total_q[5:0];
	assign pad_start = q_item.byte_present ? pos + 1'b1 : pos;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || digest.ready);

	// Byte write path, shared by message bytes and padding.
	always_comb begin
		byte_we  = 1'b0;
		byte_pos = pos;
		byte_val = q_item.data_byte;
		if (state_q == ST_IDLE) begin
			byte_we = pop & q_item.byte_present;
		end else if (state_q == ST_PAD) begin
			byte_we  = 1'b1;
			byte_pos = pad_pos_q;
			byte_val = first_q ? PAD_BYTE : 8'h00;
		end
	end

	assign byte_sh   = {~byte_pos[1:0], 3'b000};
	assign byte_word = (byte_pos[1:0] == 2'd0) ? {byte_val, 24'h0}
		: (w_q[byte_pos[5:2]] | ({24'h0, byte_val} << byte_sh));

	assign start_comp = (pop && q_item.byte_present && pos == 6'h3f)
		|| (state_q == ST_PAD && pad_pos_q == 6'h3f)
		|| (state_q == ST_LEN);

	// Round function.
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K_1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_3;
		end
	end

	assign t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

	// Block buffer; during rounds it doubles as the message schedule window.
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= w_new;
		end else if (state_q == ST_LEN) begin
			w_q[BLOCK_WORDS - 2] <= total_q[60:29];
			w_q[BLOCK_WORDS - 1] <= {total_q[28:0], 3'b000};
		end else if (byte_we) begin
			w_q[byte_pos[5:2]] <= byte_word;
		end
	end

	// Working variables.
	always_ff @(posedge clk) begin
		if (start_comp) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_word_q <= h_q[emit_idx_q];
			out_num_q  <= emit_idx_q;
			out_last_q <= emit_idx_q == 3'(DIGEST_WORDS - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= H_INIT;
			rnd_q       <= '0;
			total_q     <= '0;
			pad_pos_q   <= '0;
			first_q     <= 1'b0;
			extra_q     <= 1'b0;
			pend_pad_q  <= 1'b0;
			final_q     <= 1'b0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_item.byte_present) begin
							total_q <= total_q + 1'b1;
						end
						pad_pos_q  <= pad_start;
						first_q    <= 1'b1;
						extra_q    <= pad_start[5:3] == 3'b111;
						pend_pad_q <= q_item.end_of_message;
						final_q    <= 1'b0;
						if (q_item.byte_present && pos == 6'h3f) begin
							state_q <= ST_ROUND;
						end else if (q_item.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q   <= 1'b0;
					pad_pos_q <= pad_pos_q + 1'b1;
					if (pad_pos_q == 6'h3f) begin
						// length did not fit: fold this block, pad a fresh one
						extra_q    <= 1'b0;
						pend_pad_q <= 1'b1;
						final_q    <= 1'b0;
						state_q    <= ST_ROUND;
					end else if (!extra_q && pad_pos_q == 6'(LEN_BYTE - 1)) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					final_q <= 1'b1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (rnd_q == 7'(ROUNDS - 1)) begin
						rnd_q   <= '0;
						state_q <= ST_FOLD;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				ST_FOLD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					if (final_q) begin
						emit_idx_q <= '0;
						state_q    <= ST_EMIT;
					end else if (pend_pad_q) begin
						pend_pad_q <= 1'b0;
						state_q    <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						emit_idx_q <= emit_idx_q + 1'b1;
						if (emit_idx_q == 3'(DIGEST_WORDS - 1)) begin
							// restart the chain for the next message
							h_q     <= H_INIT;
							total_q <= '0;
							final_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_number = out_num_q;
	assign digest.last_word   = out_last_q;

	`SHA1MD_ASSERT_IMP(a_rnd_range, state_q == ST_ROUND, rnd_q < 7'(ROUNDS), "round count overrun")
	`SHA1MD_ASSERT_NXT(a_fold_final, state_q == ST_FOLD && final_q, state_q == ST_EMIT, "final fold did not emit")
	`SHA1MD_ASSERT_NXT(a_chain_clr, emit_load && emit_idx_q == 3'(DIGEST_WORDS - 1), total_q == '0 && h_q[0] == H_INIT[0], "chain not restarted")
	`SHA1MD_ASSERT_IMP(a_pad_bound, state_q == ST_PAD && !extra_q, pad_pos_q < 6'(LEN_BYTE), "padding ran into length field")

endmodule

// ----- test/tb_sha1_message_digest.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest
// Sends byte streams over msg and checks each digest word on the digest
// channel against a SHA-1 predictor in the bench. The stimulus covers empty
// and ignored items, single-byte and short messages, and long messages that
// cross the padding and block boundaries. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;
	import sha1md_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [31:0] value;
		logic [2:0]  position;
		logic        is_last;
	} digest_word_t;

	logic clk;
	logic arst_n;

	sha1md_in_if  msg_ch ();
	sha1md_out_if dig_ch ();

	sha1_message_digest uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	// Predictor state
	logic [31:0] chain_h [DIGEST_WORDS];
	logic [31:0] block_w [BLOCK_WORDS];
	logic [60:0] byte_count;

	digest_word_t pending_digest_words [$];
	digest_word_t expected_word;

	int mismatch_count = 0;
	int cycle_count    = 0;
	int items_sent     = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function void compress_block();
		logic [31:0] w [ROUNDS];
		logic [31:0] a, b, c, d, e, f, k, t;
		int i;
		for (i = 0; i < BLOCK_WORDS; i++)
			w[i] = block_w[i];
		for (i = BLOCK_WORDS; i < ROUNDS; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (i = 0; i < ROUNDS; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_2;
			end else begin
				f = b ^ c ^ d;
				k = K_3;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	// Place one byte big-endian; the first byte of a word clears the rest.
	function void place_byte(input int pos, input logic [7:0] v);
		int idx;
		int sh;
		idx = pos / 4;
		sh  = (3 - pos % 4) * 8;
		if (pos % 4 == 0)
			block_w[idx] = {v, 24'h0};
		else
			block_w[idx] |= 32'(v) << sh;
	endfunction

	function void restart_chain();
		int i;
		for (i = 0; i < DIGEST_WORDS; i++)
			chain_h[i] = H_INIT[i];
		byte_count = '0;
	endfunction

	function void absorb_item(input logic [7:0] b, input logic p, input logic e);
		int pos;
		int i;
		logic [63:0] bit_len;
		digest_word_t r;
		if (p) begin
			pos = int'(byte_count[5:0]);
			place_byte(pos, b);
			byte_count = byte_count + 61'd1;
			if (pos == 63)
				compress_block();
		end
		if (!e)
			return;
		pos = int'(byte_count[5:0]);
		place_byte(pos, PAD_BYTE);
		for (i = pos + 1; i < 64; i++)
			place_byte(i, 8'h00);
		// No room for the length: flush this block and pad a fresh one.
		if (pos >= LEN_BYTE) begin
			compress_block();
			for (i = 0; i < BLOCK_WORDS; i++)
				block_w[i] = '0;
		end
		bit_len = {byte_count, 3'b000};
		block_w[14] = bit_len[63:32];
		block_w[15] = bit_len[31:0];
		compress_block();
		for (i = 0; i < DIGEST_WORDS; i++) begin
			r.value    = chain_h[i];
			r.position = 3'(i);
			r.is_last  = (i == DIGEST_WORDS - 1);
			pending_digest_words = {pending_digest_words, r};
		end
		restart_chain();
	endfunction

	// Receiver: stall at random.
	always @(negedge clk)
		dig_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// Digest checker
	always @(posedge clk) begin
		if (arst_n && dig_ch.valid && dig_ch.ready) begin
			if (pending_digest_words.size() == 0) begin
				$display("%0t: unexpected digest transfer, actual word %h num %0d last %b",
					$time, dig_ch.digest_word, dig_ch.word_number, dig_ch.last_word);
				mismatch_count++;
			end else begin
				expected_word = pending_digest_words.pop_front();
				if (dig_ch.digest_word !== expected_word.value) begin
					$display("%0t: digest_word mismatch, expected %h actual %h",
						$time, expected_word.value, dig_ch.digest_word);
					mismatch_count++;
				end
				if (dig_ch.word_number !== expected_word.position) begin
					$display("%0t: word_number mismatch, expected %0d actual %0d",
						$time, expected_word.position, dig_ch.word_number);
					mismatch_count++;
				end
				if (dig_ch.last_word !== expected_word.is_last) begin
					$display("%0t: last_word mismatch, expected %b actual %b",
						$time, expected_word.is_last, dig_ch.last_word);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic [7:0] b, input logic p, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_ch.valid <= 1'b0;
			@(negedge clk);
		end
		msg_ch.valid          <= 1'b1;
		msg_ch.data_byte      <= b;
		msg_ch.byte_present   <= p;
		msg_ch.end_of_message <= e;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		absorb_item(b, p, e);
		if (p || e)
			items_sent++;
		@(negedge clk);
	endtask

	// Random content, occasional ignored items, and either closing style.
	task automatic send_message(input int len);
		int i;
		logic close_empty;
		close_empty = (len == 0) || ($urandom_range(1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !close_empty);
		end
		if (close_empty)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic test_empty_message();
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
	endtask

	task automatic test_ignored_items();
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h5a, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
	endtask

	task automatic test_single_bytes();
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
	endtask

	task automatic test_abc();
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
	endtask

	// One long message in the given length range, then short ones.
	task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
			input int long_lo, input int long_hi);
		int start_count;
		start_count   = items_sent;
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		send_message($urandom_range(long_hi, long_lo));
		while (items_sent - start_count < 50)
			send_message($urandom_range(12));
	endtask

	task automatic finish_run();
		msg_ch.valid <= 1'b0;
		while (pending_digest_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	endtask

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		msg_ch.valid          = 1'b0;
		msg_ch.data_byte      = 8'h00;
		msg_ch.byte_present   = 1'b0;
		msg_ch.end_of_message = 1'b0;
		dig_ch.ready          = 1'b0;
		restart_chain();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 29;
		recv_idle_pct = 75;
		test_empty_message();
		test_ignored_items();
		test_single_bytes();
		test_abc();

		// Length field fits after the pad, needs a second block, spans blocks.
		test_random_traffic(29, 75, 52, 55);
		test_random_traffic(75, 29, 56, 63);
		test_random_traffic(0, 0, 64, 70);

		finish_run();
	end

endmodule
